// ===== rtl/core/wlpm_pkg.sv =====
// ---------------------------------------------------------------------------
// wlpm_pkg
// Shared types, codes and constant tables of the window/log palette mapper.
// ---------------------------------------------------------------------------
package wlpm_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 32;
   localparam int PAL_DEPTH           = 256;
   localparam int PAL_AW              = 8;

   typedef enum logic [1:0] {
      KIND_PIXEL = 2'd0,
      KIND_RGB   = 2'd1,
      KIND_RAW   = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_WINDOW_MIN = 2'd0,
      CSR_SLOPE_GAIN = 2'd1,
      CSR_LOG_ENABLE = 2'd2,
      CSR_BLUE_FIRST = 2'd3
   } csr_index_type;

   typedef logic [7:0]  lut8_type  [PAL_DEPTH];
   typedef logic [31:0] lut32_type [PAL_DEPTH];

   // floor(p / 255) for p <= 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] p);
      logic [16:0] sum;
      sum = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
      return sum[15:8];
   endfunction

   // entry layout: red [31:24], green [23:16], blue [15:8], alpha [7:0]
   function automatic lut32_type build_ramp_lut();
      lut32_type   lut;
      logic [7:0]  c;
      logic [15:0] sq;
      for (int i = 0; i < PAL_DEPTH; i++) begin
         sq     = 16'(i * i);
         c      = div255(sq);
         lut[i] = {c, c, c, 8'(i)};
      end
      return lut;
   endfunction

   // entry i: floor(floor(log2((i+1)^255)) / 8), exact big integer
   function automatic lut8_type build_log_lut();
      lut8_type      lut;
      logic [2047:0] big;
      int            lg;
      for (int x = 1; x <= PAL_DEPTH; x++) begin
         big = 2048'd1;
         for (int k = 0; k < 255; k++) begin
            big = big * 2048'(x);
         end
         lg = 0;
         for (int w = 0; w < 64; w++) begin
            if (big[w*32 +: 32] != 32'd0) begin
               for (int b = 0; b < 32; b++) begin
                  if (big[w*32 + b]) begin
                     lg = w * 32 + b;
                  end
               end
            end
         end
         lut[x-1] = (lg / 8 > 255) ? 8'hFF : 8'(lg / 8);
      end
      return lut;
   endfunction

   localparam lut32_type RAMP_LUT = build_ramp_lut();
   localparam lut8_type  LOG_LUT  = build_log_lut();

endpackage

// ===== rtl/core/window_log_palette_pixel_mapper.sv =====
// ---------------------------------------------------------------------------
// window_log_palette_pixel_mapper
// Windowed, optionally log-shaped palette lookup from samples to RGBA pixels.
// ---------------------------------------------------------------------------
// Registers after subtract, multiply, retime, saturate/log + palette read and
//    output select lie between the accepting edge and rsp_valid.
// Throughput: one item per cycle while rsp_ready does not hold the output back.
// Palette writes take effect in the read stage, so later pixels see them.
// Reset: synchronous; clears the stage valid bits and the per-entry valid bits,
//    which makes every palette entry read as the gray ramp immediately.
module window_log_palette_pixel_mapper
   import wlpm_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_kind,
   input  logic [SAMPLE_BITS-1:0] req_sample,
   input  logic [7:0]             req_entry_index,
   input  logic [7:0]             req_entry_red,
   input  logic [7:0]             req_entry_green,
   input  logic [7:0]             req_entry_blue,
   input  logic [7:0]             req_entry_alpha,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_byte0,
   output logic [7:0]             rsp_byte1,
   output logic [7:0]             rsp_byte2,
   output logic [7:0]             rsp_byte3,
   input  logic                   csr_write_en,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_data
);

   localparam int DIFF_W = 33;

   // configuration
   logic signed [31:0] window_min_ff;
   logic [31:0]        slope_gain_ff;
   logic               log_enable_ff;
   logic               blue_first_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_min_ff <= '0;
         slope_gain_ff <= 32'd16777216;
         log_enable_ff <= 1'b0;
         blue_first_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_WINDOW_MIN: window_min_ff <= csr_data;
            CSR_SLOPE_GAIN: slope_gain_ff <= csr_data;
            CSR_LOG_ENABLE: log_enable_ff <= csr_data[0];
            CSR_BLUE_FIRST: blue_first_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic v1_in, v2_in, v3_in, v4_in, rsp_valid_in;
   kind_type kind1_ff, kind2_ff, kind3_ff;
   logic ld_out, free4, fire3, free3, free2, free1;
   logic is_write3;

   assign is_write3 = (kind3_ff == KIND_RGB) || (kind3_ff == KIND_RAW);
   assign ld_out    = !rsp_valid_ff || rsp_ready;
   assign free4     = !v4_ff || ld_out;
   assign fire3     = v3_ff && (is_write3 || free4);
   assign free3     = !v3_ff || fire3;
   assign free2     = !v2_ff || free3;
   assign free1     = !v1_ff || free2;
   assign req_ready = free1;

   assign v1_in        = free1 ? (req_valid && (kind_type'(req_kind) != KIND_NONE)) : v1_ff;
   assign v2_in        = free2 ? v1_ff : v2_ff;
   assign v3_in        = free3 ? v2_ff : v3_ff;
   assign v4_in        = free4 ? (v3_ff && (kind3_ff == KIND_PIXEL)) : v4_ff;
   assign rsp_valid_in = ld_out ? v4_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage 1: window subtract
   logic signed [DIFF_W-1:0] sample_ext;
   logic signed [DIFF_W-1:0] diff;
   logic                     diff_pos;

   assign sample_ext = {{(DIFF_W-SAMPLE_BITS){req_sample[SAMPLE_BITS-1]}}, req_sample};
   assign diff       = sample_ext - {window_min_ff[31], window_min_ff};
   assign diff_pos   = !diff[DIFF_W-1] && (diff != '0);

   logic [31:0] mag1_ff;
   logic [7:0]  idx1_ff, red1_ff, green1_ff, blue1_ff, alpha1_ff;

   always_ff @(posedge clock) begin
      if (free1) begin
         kind1_ff  <= kind_type'(req_kind);
         mag1_ff   <= diff_pos ? diff[31:0] : '0;
         idx1_ff   <= req_entry_index;
         red1_ff   <= req_entry_red;
         green1_ff <= req_entry_green;
         blue1_ff  <= req_entry_blue;
         alpha1_ff <= req_entry_alpha;
      end
   end

   // stage 2: gain multiply and premultiply products
   logic [63:0] prod2_ff;
   logic [15:0] pr2_ff, pg2_ff, pb2_ff;
   logic [7:0]  idx2_ff, red2_ff, green2_ff, blue2_ff, alpha2_ff;

   always_ff @(posedge clock) begin
      if (free2) begin
         kind2_ff  <= kind1_ff;
         prod2_ff  <= {32'd0, mag1_ff} * {32'd0, slope_gain_ff};
         pr2_ff    <= {8'd0, red1_ff} * {8'd0, idx1_ff};
         pg2_ff    <= {8'd0, green1_ff} * {8'd0, idx1_ff};
         pb2_ff    <= {8'd0, blue1_ff} * {8'd0, idx1_ff};
         idx2_ff   <= idx1_ff;
         red2_ff   <= red1_ff;
         green2_ff <= green1_ff;
         blue2_ff  <= blue1_ff;
         alpha2_ff <= alpha1_ff;
      end
   end

   // stage 3 payload
   logic [63:0] prod3_ff;
   logic [15:0] pr3_ff, pg3_ff, pb3_ff;
   logic [7:0]  idx3_ff, red3_ff, green3_ff, blue3_ff, alpha3_ff;

   always_ff @(posedge clock) begin
      if (free3) begin
         kind3_ff  <= kind2_ff;
         prod3_ff  <= prod2_ff;
         pr3_ff    <= pr2_ff;
         pg3_ff    <= pg2_ff;
         pb3_ff    <= pb2_ff;
         idx3_ff   <= idx2_ff;
         red3_ff   <= red2_ff;
         green3_ff <= green2_ff;
         blue3_ff  <= blue2_ff;
         alpha3_ff <= alpha2_ff;
      end
   end

   // stage 3: saturate, log curve, palette access
   logic [7:0]        sat_idx;
   logic [PAL_AW-1:0] rd_addr;
   logic              mem_we;
   logic [31:0]       wr_data;

   assign sat_idx = (prod3_ff[63:24] != '0) ? 8'hFF : prod3_ff[23:16];
   assign rd_addr = log_enable_ff ? LOG_LUT[sat_idx] : sat_idx;
   assign mem_we  = v3_ff && is_write3;
   assign wr_data = (kind3_ff == KIND_RAW)
                  ? {red3_ff, green3_ff, blue3_ff, alpha3_ff}
                  : {div255(pr3_ff), div255(pg3_ff), div255(pb3_ff), idx3_ff};

   logic [31:0]          pal_mem [PAL_DEPTH];
   logic [PAL_DEPTH-1:0] pal_valid_ff;
   logic [31:0]          pal_q_ff;
   logic                 pal_hit_ff;
   logic [PAL_AW-1:0]    addr4_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pal_mem[idx3_ff] <= wr_data;
      end
      if (free4) begin
         pal_q_ff <= pal_mem[rd_addr];
         addr4_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pal_valid_ff <= '0;
         pal_hit_ff   <= 1'b0;
      end else begin
         if (mem_we) begin
            pal_valid_ff[idx3_ff] <= 1'b1;
         end
         if (free4) begin
            pal_hit_ff <= pal_valid_ff[rd_addr];
         end
      end
   end

   // stage 4: entry select and byte order
   logic [31:0] entry4;
   logic [7:0]  byte0_in, byte2_in;
   logic [7:0]  byte0_ff, byte1_ff, byte2_ff, byte3_ff;

   assign entry4   = pal_hit_ff ? pal_q_ff : RAMP_LUT[addr4_ff];
   assign byte0_in = blue_first_ff ? entry4[15:8] : entry4[31:24];
   assign byte2_in = blue_first_ff ? entry4[31:24] : entry4[15:8];

   always_ff @(posedge clock) begin
      if (ld_out) begin
         byte0_ff <= byte0_in;
         byte1_ff <= entry4[23:16];
         byte2_ff <= byte2_in;
         byte3_ff <= entry4[7:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_byte0 = byte0_ff;
   assign rsp_byte1 = byte1_ff;
   assign rsp_byte2 = byte2_ff;
   assign rsp_byte3 = byte3_ff;

endmodule

// ===== rtl/core/wlpm_checker.sv =====
// ---------------------------------------------------------------------------
// wlpm_checker
// Port-level checks of the palette mapper, bound to the top level.
// ---------------------------------------------------------------------------
module wlpm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_byte0,
   input logic [7:0] rsp_byte1,
   input logic [7:0] rsp_byte2,
   input logic [7:0] rsp_byte3
);

   a_reset_empty : assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("pipeline not empty after reset");

   a_free_when_idle : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with no item waiting at the output");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("item dropped while stalled");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_byte0) && $stable(rsp_byte1)
                                     && $stable(rsp_byte2) && $stable(rsp_byte3)))
      else $error("item changed while stalled");

endmodule

bind window_log_palette_pixel_mapper wlpm_checker u_wlpm_checker (.*);
